[hdl/bitsliced_ternary_vector_alu_core_assert.svh]
// Assertion macros for the checker of the ternary vector ALU.
`ifndef BITSLICED_TERNARY_VECTOR_ALU_CORE_ASSERT_SVH
`define BITSLICED_TERNARY_VECTOR_ALU_CORE_ASSERT_SVH

// Property checked in every cycle outside reset.
`define BTVA_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("btva check failed");

// Property whose consequent must hold in the cycle after the antecedent, outside reset.
`define BTVA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("btva check failed");

// Property that also holds across reset.
`define BTVA_ASSERT_RESET(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("btva reset check failed");

`endif

[hdl/btva_pkg.sv]
// Shared types, operation codes and mod-3 helpers for the ternary vector ALU.
package btva_pkg;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_SUB = 2'd1;
  localparam logic [1:0] FUNC_MUL = 2'd2;
  localparam logic [1:0] FUNC_DOT = 2'd3;

  // Mod-3 residue codes; a sum of two is reported as minus one.
  localparam logic [1:0] RES_TWO   = 2'd2;
  localparam logic [1:0] DOT_MINUS = 2'b11;

  // Depth of the queue between the front and the back end.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  // Control part of a classified item.
  typedef struct packed {
    logic       is_dot;
    logic       last;
    logic [1:0] residue;
  } btva_ctrl_t;

  // Adds two residues in 0..2 and reduces the result mod 3.
  function automatic logic [1:0] add_mod3(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 3'd3) begin
      s = s - 3'd3;
    end
    return s[1:0];
  endfunction

endpackage

[hdl/btva_front.sv]
// Front end: accepts items, applies the trit logic and reduces the product weight mod 3.
module btva_front import btva_pkg::*; #(
  parameter int WORD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           func,
  input  logic [WORD_BITS-1:0] x_plus_plane,
  input  logic [WORD_BITS-1:0] x_minus_plane,
  input  logic [WORD_BITS-1:0] y_plus_plane,
  input  logic [WORD_BITS-1:0] y_minus_plane,
  input  logic                 last_word,
  output logic                 item_valid,
  input  logic                 item_ready,
  output logic [WORD_BITS-1:0] item_plus,
  output logic [WORD_BITS-1:0] item_minus,
  output btva_ctrl_t           item_ctrl
);

  localparam int LEVELS = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] yp;
  logic [WORD_BITS-1:0] ym;
  logic [WORD_BITS-1:0] sp;
  logic [WORD_BITS-1:0] sm;
  logic [WORD_BITS-1:0] zp_next;
  logic [WORD_BITS-1:0] zm_next;
  logic [1:0]           leaf [WORD_BITS];
  btva_ctrl_t           ctrl_next;
  logic                 accept;

  // Subtract is an add with the y planes swapped.
  always_comb begin
    yp = (func == FUNC_SUB) ? y_minus_plane : y_plus_plane;
    ym = (func == FUNC_SUB) ? y_plus_plane  : y_minus_plane;
    sp = x_plus_plane  ^ yp;
    sm = x_minus_plane ^ ym;
  end

  // Per-position trit operation.
  always_comb begin
    unique case (func)
      FUNC_ADD, FUNC_SUB: begin
        zp_next = (sp & sm) ^ (x_minus_plane & ym) ^ sp;
        zm_next = (sp & sm) ^ sm ^ (x_plus_plane & yp);
      end
      default: begin
        zp_next = (x_plus_plane & y_plus_plane) ^ (x_minus_plane & y_minus_plane);
        zm_next = (x_plus_plane & y_minus_plane) ^ (x_minus_plane & y_plus_plane);
      end
    endcase
  end

  // Weight of the product mod 3: a plus bit counts one, a minus bit two, summed by a tree.
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      leaf[i] = add_mod3({1'b0, zp_next[i]}, {zm_next[i], 1'b0});
    end
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      for (int i = 0; i + (1 << lvl) < WORD_BITS; i += (2 << lvl)) begin
        leaf[i] = add_mod3(leaf[i], leaf[i + (1 << lvl)]);
      end
    end
    ctrl_next.is_dot  = (func == FUNC_DOT);
    ctrl_next.last    = last_word;
    ctrl_next.residue = leaf[0];
  end

  // Holding register: takes a new item when empty or when its item moves on.
  assign full   = item_valid && !item_ready;
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_plus  <= zp_next;
      item_minus <= zm_next;
      item_ctrl  <= ctrl_next;
    end
  end

endmodule

[hdl/btva_queue.sv]
// Short register queue that decouples the front end from the back end.
module btva_queue import btva_pkg::*; #(
  parameter int WORD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  logic [WORD_BITS-1:0] wr_plus,
  input  logic [WORD_BITS-1:0] wr_minus,
  input  btva_ctrl_t           wr_ctrl,
  output logic                 rd_valid,
  input  logic                 rd_take,
  output logic [WORD_BITS-1:0] rd_plus,
  output logic [WORD_BITS-1:0] rd_minus,
  output btva_ctrl_t           rd_ctrl
);

  logic [WORD_BITS-1:0]   plus_q  [QUEUE_DEPTH];
  logic [WORD_BITS-1:0]   minus_q [QUEUE_DEPTH];
  btva_ctrl_t             ctrl_q  [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_wr;
  logic                   do_rd;

  assign wr_ready = (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_take && rd_valid;

  assign rd_plus  = plus_q[rd_ptr];
  assign rd_minus = minus_q[rd_ptr];
  assign rd_ctrl  = ctrl_q[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      plus_q[wr_ptr]  <= wr_plus;
      minus_q[wr_ptr] <= wr_minus;
      ctrl_q[wr_ptr]  <= wr_ctrl;
    end
  end

endmodule

[hdl/btva_back.sv]
// Back end: keeps the running dot sum and holds the result item for the consumer.
module btva_back import btva_pkg::*; #(
  parameter int WORD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_take,
  input  logic [WORD_BITS-1:0] in_plus,
  input  logic [WORD_BITS-1:0] in_minus,
  input  btva_ctrl_t           in_ctrl,
  output logic                 empty,
  input  logic                 pop,
  output logic [WORD_BITS-1:0] z_plus_plane,
  output logic [WORD_BITS-1:0] z_minus_plane,
  output logic [1:0]           dot_value,
  output logic                 dot_valid
);

  logic       out_valid;
  logic [1:0] acc;
  logic [1:0] acc_sum;
  logic       finish;

  // The output register refills whenever it is free or being drained.
  assign empty   = !out_valid;
  assign in_take = in_valid && (!out_valid || pop);
  assign acc_sum = add_mod3(acc, in_ctrl.residue);
  assign finish  = in_ctrl.is_dot && in_ctrl.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      acc       <= '0;
    end else begin
      if (in_take) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      // Running sum only moves on dot steps; the last word clears it.
      if (in_take && in_ctrl.is_dot) begin
        acc <= finish ? 2'd0 : acc_sum;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_take) begin
      z_plus_plane  <= in_plus;
      z_minus_plane <= in_minus;
      dot_valid     <= finish;
      if (!finish) begin
        dot_value <= 2'd0;
      end else if (acc_sum == RES_TWO) begin
        dot_value <= DOT_MINUS;
      end else begin
        dot_value <= acc_sum;
      end
    end
  end

endmodule

[hdl/bitsliced_ternary_vector_alu_core.sv]
// Top level of the bitsliced GF(3) vector ALU.
// Each item carries one word of two GF(3) vectors as plus and minus bit planes and returns
// one result item: the add, subtract or componentwise multiply planes, and in dot mode
// (func 3) the running dot product, reported as -1, 0 or 1 with dot_valid on the item
// marked last_word, after which the sum restarts at zero. The block takes one item per
// clock while full is low; the front end does all trit logic and the mod-3 weight tree,
// and the only item-to-item dependency is the two-bit mod-3 accumulator update in the
// back end. A result passes the front holding register, a queue entry and the back output
// register; a two-entry queue between the front and back lets either side stall on its own.
module bitsliced_ternary_vector_alu_core import btva_pkg::*; #(
  parameter int WORD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           func,
  input  logic [WORD_BITS-1:0] x_plus_plane,
  input  logic [WORD_BITS-1:0] x_minus_plane,
  input  logic [WORD_BITS-1:0] y_plus_plane,
  input  logic [WORD_BITS-1:0] y_minus_plane,
  input  logic                 last_word,
  output logic                 empty,
  input  logic                 pop,
  output logic [WORD_BITS-1:0] z_plus_plane,
  output logic [WORD_BITS-1:0] z_minus_plane,
  output logic signed [1:0]    dot_value,
  output logic                 dot_valid
);

  logic                 f_valid;
  logic                 f_ready;
  logic [WORD_BITS-1:0] f_plus;
  logic [WORD_BITS-1:0] f_minus;
  btva_ctrl_t           f_ctrl;
  logic                 q_valid;
  logic                 q_take;
  logic [WORD_BITS-1:0] q_plus;
  logic [WORD_BITS-1:0] q_minus;
  btva_ctrl_t           q_ctrl;
  logic [1:0]           dot_bits;

  // Front end: accept and compute.
  btva_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .func          (func),
    .x_plus_plane  (x_plus_plane),
    .x_minus_plane (x_minus_plane),
    .y_plus_plane  (y_plus_plane),
    .y_minus_plane (y_minus_plane),
    .last_word     (last_word),
    .item_valid    (f_valid),
    .item_ready    (f_ready),
    .item_plus     (f_plus),
    .item_minus    (f_minus),
    .item_ctrl     (f_ctrl)
  );

  // Decoupling queue.
  btva_queue #(.WORD_BITS(WORD_BITS)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_plus  (f_plus),
    .wr_minus (f_minus),
    .wr_ctrl  (f_ctrl),
    .rd_valid (q_valid),
    .rd_take  (q_take),
    .rd_plus  (q_plus),
    .rd_minus (q_minus),
    .rd_ctrl  (q_ctrl)
  );

  // Back end: accumulate and present results.
  btva_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (q_valid),
    .in_take       (q_take),
    .in_plus       (q_plus),
    .in_minus      (q_minus),
    .in_ctrl       (q_ctrl),
    .empty         (empty),
    .pop           (pop),
    .z_plus_plane  (z_plus_plane),
    .z_minus_plane (z_minus_plane),
    .dot_value     (dot_bits),
    .dot_valid     (dot_valid)
  );

  assign dot_value = $signed(dot_bits);

endmodule

[hdl/btva_checker.sv]
// Port-level checker for the ternary vector ALU and its bind to the top level.
`include "bitsliced_ternary_vector_alu_core_assert.svh"

module btva_checker #(
  parameter int WORD_BITS = 64
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 full,
  input logic                 empty,
  input logic                 pop,
  input logic [WORD_BITS-1:0] z_plus_plane,
  input logic signed [1:0]    dot_value,
  input logic                 dot_valid
);

  // Reset leaves no result waiting and room for an item.
  `BTVA_ASSERT_RESET(a_reset_clear, rst, empty && !full)

  // A finished dot product is never the unused code.
  `BTVA_ASSERT_ALWAYS(a_dot_code, empty || !dot_valid || dot_value != 2'sb10)

  // A nonzero dot value only comes with a finished dot product.
  `BTVA_ASSERT_ALWAYS(a_dot_flag, empty || dot_valid || dot_value == 2'sb00)

  // A waiting result item holds until it is taken.
  `BTVA_ASSERT_NEXT(a_hold, !empty && !pop,
    !empty && $stable(z_plus_plane) && $stable(dot_value) && $stable(dot_valid))

endmodule

bind bitsliced_ternary_vector_alu_core btva_checker #(.WORD_BITS(WORD_BITS)) u_btva_checker (
  .clk          (clk),
  .rst          (rst),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .z_plus_plane (z_plus_plane),
  .dot_value    (dot_value),
  .dot_valid    (dot_valid)
);

[tb/tb_bitsliced_ternary_vector_alu_core.sv]
// Self-checking testbench for the bitsliced GF(3) vector ALU core.
module tb_bitsliced_ternary_vector_alu_core import btva_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ITEM_COUNT = 1100;
  localparam int          LONG_HOLD  = 80;
  localparam logic [63:0] ALL_ONES   = '1;
  localparam logic [63:0] ALT_HIGH   = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [63:0] ALT_LOW    = 64'h5555_5555_5555_5555;
  localparam logic [63:0] TOP_BIT    = 64'h8000_0000_0000_0000;

  // One input word of x and y, and the result word it produces.
  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] xp;
    logic [63:0] xm;
    logic [63:0] yp;
    logic [63:0] ym;
    logic        last;
  } gf3_word_in_t;

  typedef struct packed {
    logic [63:0]       zp;
    logic [63:0]       zm;
    logic signed [1:0] dv;
    logic              dvld;
  } gf3_word_out_t;

  // A directed row; known rows carry a result typed in by hand.
  typedef struct packed {
    gf3_word_in_t  w;
    logic          known;
    gf3_word_out_t r;
  } directed_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  logic [1:0]        func = FUNC_ADD;
  logic [63:0]       x_plus_plane = '0;
  logic [63:0]       x_minus_plane = '0;
  logic [63:0]       y_plus_plane = '0;
  logic [63:0]       y_minus_plane = '0;
  logic              last_word = 1'b0;
  logic              empty;
  logic              pop = 1'b0;
  logic [63:0]       z_plus_plane;
  logic [63:0]       z_minus_plane;
  logic signed [1:0] dot_value;
  logic              dot_valid;

  // Side information that travels with the item being offered.
  logic              item_known = 1'b0;
  gf3_word_out_t     item_result = '0;

  gf3_word_out_t     alu_word_q[$];
  directed_row_t     directed_rows[$];
  logic [1:0]        dot_sum_model = '0;
  int                n_accepted = 0;
  int                n_sent = 0;
  int                n_checked = 0;
  int                n_dot_done = 0;
  int                n_fail = 0;
  int                n_directed = 0;

  bitsliced_ternary_vector_alu_core #(.WORD_BITS(64)) dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .func          (func),
    .x_plus_plane  (x_plus_plane),
    .x_minus_plane (x_minus_plane),
    .y_plus_plane  (y_plus_plane),
    .y_minus_plane (y_minus_plane),
    .last_word     (last_word),
    .empty         (empty),
    .pop           (pop),
    .z_plus_plane  (z_plus_plane),
    .z_minus_plane (z_minus_plane),
    .dot_value     (dot_value),
    .dot_valid     (dot_valid)
  );

  always #5 clk = ~clk;

  // Computes the result word and the next dot sum (held as 0, 1 or 2).
  function automatic gf3_word_out_t predict_alu_word(input gf3_word_in_t w,
                                                     input logic [1:0] sum_in,
                                                     output logic [1:0] sum_out);
    gf3_word_out_t res;
    logic [63:0]   bp;
    logic [63:0]   bm;
    logic [63:0]   sp;
    logic [63:0]   sm;
    int            total;
    res = '0;
    sum_out = sum_in;
    if (w.op == FUNC_ADD || w.op == FUNC_SUB) begin
      // Subtraction is addition with the y planes swapped.
      bp = (w.op == FUNC_SUB) ? w.ym : w.yp;
      bm = (w.op == FUNC_SUB) ? w.yp : w.ym;
      sp = w.xp ^ bp;
      sm = w.xm ^ bm;
      res.zp = (sp & sm) ^ (w.xm & bm) ^ sp;
      res.zm = (sp & sm) ^ sm ^ (w.xp & bp);
    end else begin
      res.zp = (w.xp & w.yp) ^ (w.xm & w.ym);
      res.zm = (w.xp & w.ym) ^ (w.xm & w.yp);
      if (w.op == FUNC_DOT) begin
        total = (int'(sum_in) + $countones(res.zp) + 2 * $countones(res.zm)) % 3;
        if (w.last) begin
          res.dv = (total == int'(RES_TWO)) ? DOT_MINUS : 2'(total);
          res.dvld = 1'b1;
          sum_out = '0;
        end else begin
          sum_out = 2'(total);
        end
      end
    end
    return res;
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Random plane pair: valid trits of varying density, invalid pairs and extremes.
  function automatic void make_planes(output logic [63:0] p, output logic [63:0] m);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    int          r;
    a = {$urandom(), $urandom()};
    b = {$urandom(), $urandom()};
    c = {$urandom(), $urandom()};
    r = $urandom_range(0, 99);
    if (r < 45) begin
      p = a;
      m = b & ~a;
    end else if (r < 65) begin
      p = a & b;
      m = ~a & ~b & c;
    end else if (r < 82) begin
      p = a;
      m = b;
    end else if (r < 92) begin
      p = c[0] ? ALL_ONES : '0;
      m = c[0] ? '0 : ALL_ONES;
    end else begin
      p = '0;
      m = '0;
    end
  endfunction

  task automatic add_known(input logic [1:0] op, input logic [63:0] xp, input logic [63:0] xm,
                           input logic [63:0] yp, input logic [63:0] ym, input logic last,
                           input logic [63:0] zp, input logic [63:0] zm,
                           input logic signed [1:0] dv, input logic dvld);
    directed_rows.push_back('{w: '{op, xp, xm, yp, ym, last}, known: 1'b1,
                              r: '{zp, zm, dv, dvld}});
  endtask

  task automatic add_row(input logic [1:0] op, input logic [63:0] xp, input logic [63:0] xm,
                         input logic [63:0] yp, input logic [63:0] ym, input logic last);
    directed_rows.push_back('{w: '{op, xp, xm, yp, ym, last}, known: 1'b0, r: '0});
  endtask

  // Offers one item after an optional gap and returns once it is accepted.
  // Called and returns at a falling edge.
  task automatic send_word(input gf3_word_in_t w, input logic known,
                           input gf3_word_out_t r);
    int gap;
    int seen;
    gap = ((n_sent / 150) % 4 == 3) ? 0 : pick_gap();
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    func = w.op;
    x_plus_plane = w.xp;
    x_minus_plane = w.xm;
    y_plus_plane = w.yp;
    y_minus_plane = w.ym;
    last_word = w.last;
    item_known = known;
    item_result = r;
    push = 1'b1;
    seen = n_accepted;
    do @(negedge clk); while (n_accepted == seen);
    n_sent++;
  endtask

  task automatic send_random(input logic [1:0] op, input logic last);
    gf3_word_in_t w;
    w.op = op;
    w.last = last;
    make_planes(w.xp, w.xm);
    make_planes(w.yp, w.ym);
    send_word(w, 1'b0, '0);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  // Predict each accepted item and check each accepted result item.
  always @(posedge clk) begin : monitor
    gf3_word_out_t predicted;
    gf3_word_out_t want;
    logic [1:0]    next_sum;
    if (!rst && push && !full) begin
      predicted = predict_alu_word('{func, x_plus_plane, x_minus_plane, y_plus_plane,
                                     y_minus_plane, last_word}, dot_sum_model, next_sum);
      dot_sum_model = next_sum;
      if (item_known) begin
        predicted = item_result;
      end
      if (predicted.dvld) begin
        n_dot_done++;
      end
      alu_word_q.push_back(predicted);
      n_accepted++;
    end
    if (!rst && pop && !empty) begin
      if (alu_word_q.size() == 0) begin
        $error("Result item with no item outstanding");
        n_fail++;
      end else begin
        want = alu_word_q.pop_front();
        check_field("z_plus_plane", want.zp, z_plus_plane);
        check_field("z_minus_plane", want.zm, z_minus_plane);
        check_field("dot_value", want.dv, dot_value);
        check_field("dot_valid", want.dvld, dot_valid);
        n_checked++;
      end
    end
  end

  // Receiver: random stalls, quiet stretches, and one long hold-off mid-run.
  initial begin : drain
    int hold;
    int cyc;
    bit held_once;
    hold = 0;
    cyc = 0;
    held_once = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (!held_once && n_accepted >= 400) begin
        held_once = 1;
        pop = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (hold > 0) begin
        pop = 1'b0;
        hold--;
      end else begin
        pop = 1'b1;
        if ((cyc / 300) % 4 != 2) begin
          hold = pick_gap();
        end
      end
    end
  end

  // Run limit.
  initial begin
    #(10_000_000);
    $display("Timeout with %0d result items outstanding", alu_word_q.size());
    $display("** bitsliced_ternary_vector_alu_core: FAILED **");
    $finish;
  end

  // Stimulus: directed table, then random items and dot sequences.
  initial begin : stimulus
    logic [1:0] non_dot_ops[3];
    int         r;
    int         len;
    non_dot_ops = '{FUNC_ADD, FUNC_SUB, FUNC_MUL};

    // Rows with a typed result: zero dot after reset, extremes, last word outside dot mode.
    add_known(FUNC_DOT, '0, '0, '0, '0, 1'b1, '0, '0, 2'sd0, 1'b1);
    add_known(FUNC_ADD, ALL_ONES, '0, '0, '0, 1'b0, ALL_ONES, '0, 2'sd0, 1'b0);
    add_known(FUNC_ADD, ALL_ONES, '0, ALL_ONES, '0, 1'b0, '0, ALL_ONES, 2'sd0, 1'b0);
    add_known(FUNC_SUB, ALL_ONES, '0, ALL_ONES, '0, 1'b0, '0, '0, 2'sd0, 1'b0);
    add_known(FUNC_MUL, '0, ALL_ONES, '0, ALL_ONES, 1'b0, ALL_ONES, '0, 2'sd0, 1'b0);
    add_known(FUNC_MUL, ALL_ONES, '0, '0, ALL_ONES, 1'b0, '0, ALL_ONES, 2'sd0, 1'b0);
    add_known(FUNC_DOT, ALL_ONES, '0, ALL_ONES, '0, 1'b1, ALL_ONES, '0, 2'sd1, 1'b1);
    add_known(FUNC_DOT, ALL_ONES, '0, '0, ALL_ONES, 1'b1, '0, ALL_ONES, DOT_MINUS, 1'b1);
    add_known(FUNC_DOT, ALL_ONES, '0, ALL_ONES, '0, 1'b0, ALL_ONES, '0, 2'sd0, 1'b0);
    add_known(FUNC_ADD, '0, '0, '0, '0, 1'b1, '0, '0, 2'sd0, 1'b0);
    add_known(FUNC_DOT, '0, '0, '0, '0, 1'b1, '0, '0, 2'sd1, 1'b1);
    // Positions with both bits set, alternating patterns and single-bit words.
    add_row(FUNC_ADD, ALL_ONES, ALL_ONES, ALT_HIGH, ALT_LOW, 1'b0);
    add_row(FUNC_SUB, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b0);
    add_row(FUNC_MUL, ALL_ONES, ALL_ONES, ALT_HIGH, '0, 1'b0);
    add_row(FUNC_DOT, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b0);
    add_row(FUNC_MUL, '0, '0, '0, '0, 1'b1);
    add_row(FUNC_DOT, ALT_HIGH, ALT_LOW, ALT_LOW, ALT_HIGH, 1'b1);
    add_row(FUNC_ADD, '0, ALL_ONES, '0, ALL_ONES, 1'b0);
    add_row(FUNC_SUB, ALT_HIGH, ALT_LOW, ALT_HIGH, ALT_LOW, 1'b1);
    add_row(FUNC_DOT, 64'h1, '0, 64'h1, '0, 1'b0);
    add_row(FUNC_DOT, TOP_BIT, '0, '0, TOP_BIT, 1'b0);
    add_row(FUNC_DOT, '0, '0, '0, '0, 1'b1);
    n_directed = directed_rows.size();

    // Reset held, then released at a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].w, directed_rows[i].known, directed_rows[i].r);
    end

    // Mostly dot sequences with random content; some interrupted or left open.
    while (n_sent < ITEM_COUNT) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_random(non_dot_ops[$urandom_range(0, 2)], 1'($urandom_range(0, 1)));
          end
          send_random(FUNC_DOT, (k == len - 1) ? ($urandom_range(0, 9) != 0) : 1'b0);
        end
      end else begin
        send_random(non_dot_ops[$urandom_range(0, 2)], 1'($urandom_range(0, 1)));
      end
    end
    push = 1'b0;

    // Drain the remaining results.
    while (alu_word_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d items (%0d directed); checked %0d result items.",
             n_sent, n_directed, n_checked);
    $display("Finished %0d dot products; %0d mismatches.", n_dot_done, n_fail);
    if (n_fail == 0 && alu_word_q.size() == 0) begin
      $display("** bitsliced_ternary_vector_alu_core: PASSED **");
    end else begin
      $display("** bitsliced_ternary_vector_alu_core: FAILED **");
    end
    $finish;
  end

endmodule

[bitsliced_ternary_vector_alu_core.f]
+incdir+hdl
hdl/btva_pkg.sv
hdl/btva_front.sv
hdl/btva_queue.sv
hdl/btva_back.sv
hdl/bitsliced_ternary_vector_alu_core.sv
hdl/btva_checker.sv
tb/tb_bitsliced_ternary_vector_alu_core.sv
